>>> rtl/ecf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecf_pkg - shared types and constants for the escaped capture framer
// Byte codes, item function codes, queue command layout and the slot tables
// that the back end walks to turn one command into bytes.
// ----------------------------------------------------------------------------
package ecf_pkg;

    localparam logic [7:0] ESC_CHAR    = 8'h1b;
    localparam logic [7:0] STUFF_CHAR  = 8'h00;
    localparam logic [7:0] MARK_HEADER = 8'h01;
    localparam logic [7:0] MARK_MOSI   = 8'h02;
    localparam logic [7:0] MARK_MISO   = 8'h03;
    localparam logic [7:0] MARK_END    = 8'h04;

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_MOSI  = 2'd1;
    localparam logic [1:0] FUNC_MISO  = 2'd2;
    localparam logic [1:0] FUNC_END   = 2'd3;

    localparam logic [1:0] OP_HDR  = 2'd0;
    localparam logic [1:0] OP_DATA = 2'd1;
    localparam logic [1:0] OP_END  = 2'd2;

    localparam int SLOT_W = 4;

    typedef logic [SLOT_W-1:0] slot_t;

    // payload: header -> {count, elapsed}; data -> byte in [7:0]
    typedef struct packed {
        logic [1:0]  op;
        logic        miso;
        logic [31:0] payload;
    } cmd_t;

    typedef struct packed {
        logic [7:0] value;
        logic       is_data;
    } slot_byte_t;

    // Data and end commands skip the section mark slots unless it is due.
    function automatic slot_t slot_first(input cmd_t c);
        slot_t s;
        s = slot_t'(0);
        if ((c.op != OP_HDR) && !c.miso)
        begin
            s = slot_t'(2);
        end
        return s;
    endfunction

    function automatic slot_t slot_final(input cmd_t c);
        slot_t s;
        case (c.op)
            OP_HDR:  s = slot_t'(9);
            OP_DATA: s = slot_t'(2);
            OP_END:  s = slot_t'(3);
            default: s = slot_t'(2);
        endcase
        return s;
    endfunction

    function automatic slot_byte_t slot_byte(input cmd_t c, input slot_t s);
        slot_byte_t r;
        r.value   = STUFF_CHAR;
        r.is_data = 1'b0;
        case (c.op)
            OP_HDR:
            begin
                case (s)
                    4'd0: r.value = ESC_CHAR;
                    4'd1: r.value = MARK_HEADER;
                    4'd2: r = '{c.payload[7:0], 1'b1};
                    4'd3: r = '{c.payload[15:8], 1'b1};
                    4'd4: r = '{STUFF_CHAR, 1'b1};
                    4'd5: r = '{STUFF_CHAR, 1'b1};
                    4'd6: r = '{c.payload[23:16], 1'b1};
                    4'd7: r = '{c.payload[31:24], 1'b1};
                    4'd8: r.value = ESC_CHAR;
                    4'd9: r.value = MARK_MOSI;
                    default: r.value = STUFF_CHAR;
                endcase
            end
            OP_DATA:
            begin
                case (s)
                    4'd0: r.value = ESC_CHAR;
                    4'd1: r.value = MARK_MISO;
                    4'd2: r = '{c.payload[7:0], 1'b1};
                    default: r.value = STUFF_CHAR;
                endcase
            end
            OP_END:
            begin
                case (s)
                    4'd0: r.value = ESC_CHAR;
                    4'd1: r.value = MARK_MISO;
                    4'd2: r.value = ESC_CHAR;
                    4'd3: r.value = MARK_END;
                    default: r.value = STUFF_CHAR;
                endcase
            end
            default: r.value = STUFF_CHAR;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/ecf_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecf_if - item channels of the escaped capture framer
// Capture items in, framed stream bytes out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface ecf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  data_byte;
    logic [15:0] timestamp;

    modport source (output valid, output func, output data_byte, output timestamp,
                    input ready);
    modport sink   (input valid, input func, input data_byte, input timestamp,
                    output ready);
endinterface

interface ecf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface
`default_nettype wire

>>> rtl/ecf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecf_front - item classifier
// Accepts capture items, tracks frame state and pushes one command per item
// that produces output.
// ----------------------------------------------------------------------------
module ecf_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    ecf_in_if.sink             capture,
    input  wire logic          full,
    output logic               push,
    output ecf_pkg::cmd_t      cmd
);
    import ecf_pkg::*;

    logic        open_reg, open_next;
    logic        sec_reg, sec_next;
    logic [15:0] prev_ts_reg, prev_ts_next;
    logic [15:0] count_reg, count_next;
    logic        accept;
    logic        push_req;
    logic [15:0] elapsed;

    assign capture.ready = !full;
    assign accept        = capture.valid && !full;
    assign elapsed       = capture.timestamp - prev_ts_reg;
    assign push          = accept && push_req;

    always_comb
    begin
        open_next    = open_reg;
        sec_next     = sec_reg;
        prev_ts_next = prev_ts_reg;
        count_next   = count_reg;
        push_req     = 1'b0;
        cmd.op       = OP_DATA;
        cmd.miso     = 1'b0;
        cmd.payload  = {24'd0, capture.data_byte};
        case (capture.func)
            FUNC_START:
            begin
                push_req     = 1'b1;
                cmd.op       = OP_HDR;
                cmd.payload  = {count_reg, elapsed};
                open_next    = 1'b1;
                sec_next     = 1'b0;
                prev_ts_next = capture.timestamp;
                count_next   = count_reg + 16'd1;
            end
            FUNC_MOSI:
            begin
                push_req = open_reg && !sec_reg;
            end
            FUNC_MISO:
            begin
                push_req = open_reg;
                cmd.miso = !sec_reg;
                if (open_reg)
                begin
                    sec_next = 1'b1;
                end
            end
            FUNC_END:
            begin
                push_req = open_reg;
                cmd.op   = OP_END;
                cmd.miso = !sec_reg;
                if (open_reg)
                begin
                    open_next = 1'b0;
                    sec_next  = 1'b0;
                end
            end
            default:
            begin
                push_req = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg    <= 1'b0;
            sec_reg     <= 1'b0;
            prev_ts_reg <= 16'd0;
            count_reg   <= 16'd0;
        end
        else if (accept)
        begin
            open_reg    <= open_next;
            sec_reg     <= sec_next;
            prev_ts_reg <= prev_ts_next;
            count_reg   <= count_next;
        end
    end

    // the slave-out section can only have begun inside an open frame
    assert property (@(posedge clk) disable iff (!rst_n) sec_reg |-> open_reg)
        else $error("ecf_front: section flag set with no frame open");

    // every start item pushes a header and opens the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && capture.func == FUNC_START) |-> push ##1 open_reg)
        else $error("ecf_front: start item did not open a frame");

    // an item arriving with no frame open, other than a start, is dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !open_reg && capture.func != FUNC_START) |-> !push)
        else $error("ecf_front: item outside a frame was queued");

endmodule
`default_nettype wire

>>> rtl/ecf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecf_queue - command queue between classifier and byte emitter
// Small register FIFO, one write and one read port.
// ----------------------------------------------------------------------------
module ecf_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  ecf_pkg::cmd_t      wr_cmd,
    input  wire logic          pop,
    output ecf_pkg::cmd_t      head,
    output logic               full,
    output logic               empty
);
    import ecf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t               mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(DEPTH))
        else $error("ecf_queue: fill count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("ecf_queue: push not counted");

    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0 && wr_ptr_reg == rd_ptr_reg) |-> full)
        else $error("ecf_queue: pointers meet with queue partly filled");

endmodule
`default_nettype wire

>>> rtl/ecf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecf_back - byte emitter
// Walks the slots of the head command, one byte a cycle when not stalled,
// inserting the stuffing byte after each escape character sent as data.
// ----------------------------------------------------------------------------
module ecf_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  ecf_pkg::cmd_t      head,
    input  wire logic          empty,
    output logic               pop,
    ecf_out_if.source          stream
);
    import ecf_pkg::*;

    slot_t      slot_reg, slot_next;
    logic       started_reg, started_next;
    logic       stuff_reg, stuff_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;

    slot_t      cur_slot;
    slot_t      end_slot;
    slot_byte_t sb;
    logic       emit;
    logic       at_end;

    assign cur_slot = started_reg ? slot_reg : slot_first(head);
    assign end_slot = slot_final(head);
    assign sb       = slot_byte(head, cur_slot);
    assign at_end   = (cur_slot == end_slot);
    assign emit     = !empty && (!valid_reg || stream.ready);

    assign stream.valid       = valid_reg;
    assign stream.out_byte    = byte_reg;
    assign stream.last_of_run = last_reg;

    always_comb
    begin
        slot_next    = slot_reg;
        started_next = started_reg;
        stuff_next   = stuff_reg;
        valid_next   = valid_reg && !stream.ready;
        byte_next    = byte_reg;
        last_next    = last_reg;
        pop          = 1'b0;
        if (emit)
        begin
            valid_next = 1'b1;
            if (stuff_reg)
            begin
                byte_next  = STUFF_CHAR;
                last_next  = at_end;
                stuff_next = 1'b0;
                slot_next  = cur_slot + slot_t'(1);
            end
            else if (sb.is_data && sb.value == ESC_CHAR)
            begin
                byte_next  = sb.value;
                last_next  = 1'b0;
                stuff_next = 1'b1;
                slot_next  = cur_slot;
            end
            else
            begin
                byte_next = sb.value;
                last_next = at_end;
                slot_next = cur_slot + slot_t'(1);
            end
            pop          = last_next;
            started_next = !last_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg    <= '0;
            started_reg <= 1'b0;
            stuff_reg   <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            slot_reg    <= slot_next;
            started_reg <= started_next;
            stuff_reg   <= stuff_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    // a command half sent must still sit at the queue head
    assert property (@(posedge clk) disable iff (!rst_n) started_reg |-> !empty)
        else $error("ecf_back: command lost mid-run");

    // pending stuffing byte always belongs to a started command
    assert property (@(posedge clk) disable iff (!rst_n) stuff_reg |-> started_reg)
        else $error("ecf_back: stuffing pending outside a command");

    // the slot walk never runs past the command's final slot
    assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> (slot_reg <= end_slot))
        else $error("ecf_back: slot beyond end of command");

    // the stuffing byte follows an escape character with no end mark on it
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !stuff_reg && sb.is_data && sb.value == ESC_CHAR)
        |=> (byte_reg == ESC_CHAR && !last_reg && stuff_reg))
        else $error("ecf_back: escaped data byte not held for stuffing");

endmodule
`default_nettype wire

>>> rtl/escaped_capture_framer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// escaped_capture_framer - escape-delimited capture frame builder
// Turns start / master-out / slave-out / end items into a byte stream framed
// with ESC marks, stuffing every escape character sent as data.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  capture   in   valid/ready    func[1:0], data_byte[7:0], timestamp[15:0]
//  stream    out  valid/ready    out_byte[7:0], last_of_run
//
//  One output byte leaves per cycle while the stream is ready; an item
//  makes 0 to 14 bytes, all sent by the single byte emitter in the back end.
//  Items are taken every cycle while the command queue has room, so
//  classification runs ahead of emission by up to QUEUE_DEPTH commands.
//  Reset clears frame state, queue pointers and the output valid; no sweep.
//  A stalled stream holds its byte; the queue absorbs items meanwhile.
//
module escaped_capture_framer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ecf_in_if.sink    capture,
    ecf_out_if.source stream
);
    import ecf_pkg::*;

    // front -> queue
    logic push;
    cmd_t wr_cmd;
    logic full;

    // queue -> back
    cmd_t head;
    logic empty;
    logic pop;

    // Front end: frame state (open, slave-out section, last stamp, count) and
    // one command per productive item. Dropped items never reach the queue.
    ecf_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .capture (capture),
        .full    (full),
        .push    (push),
        .cmd     (wr_cmd)
    );

    // Decouples the two halves so a stalled stream does not block intake.
    ecf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (wr_cmd),
        .pop    (pop),
        .head   (head),
        .full   (full),
        .empty  (empty)
    );

    // Back end: slot walker plus output register; last_of_run marks the final
    // byte of each command, stuffing byte included.
    ecf_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .stream (stream)
    );

endmodule
`default_nettype wire

>>> tb/sv/escaped_capture_framer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// escaped_capture_framer_tb - self-checking bench for the capture framer
// A queue-fed driver offers start / master-out / slave-out / end items. A
// clocked monitor predicts the framed byte stream for every accepted item and
// checks each stream byte against the oldest expected byte. The run covers
// directed corners, random frames under several idle/stall mixes and a long
// receiver hold-off.
// ----------------------------------------------------------------------------
module escaped_capture_framer_tb;

    import ecf_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 7;
    localparam int HOLD_CYCLES  = 150;
    localparam int TAIL_CYCLES  = 100;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int PRINT_CAP    = 100;
    localparam int RANDOM_ITEMS = 22;

    // one capture item as offered on the input channel
    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  data_byte;
        logic [15:0] timestamp;
    } capture_item_t;

    // one byte of the framed stream as it should appear
    typedef struct packed {
        logic [7:0] value;
        logic       is_last;
    } stream_byte_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ecf_in_if  capture_ch ();
    ecf_out_if stream_ch ();

    escaped_capture_framer DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .capture (capture_ch),
        .stream  (stream_ch)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    capture_item_t pending_items[$];     // items still to be offered
    stream_byte_t  expected_stream[$];   // bytes predicted but not yet seen
    logic [7:0]    run_bytes[$];         // bytes of the item being predicted

    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          items_queued = 0;
    logic [15:0] last_ts_queued = '0;    // timestamp of the last start queued

    int   src_idle_pct = 0;
    int   sink_stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_off = 1'b0;
    logic cap_fire = 1'b0;               // capture handshake at the last rising edge

    // predictor's own copy of the framer state
    logic        pr_frame_open;
    logic        pr_miso_begun;
    logic [15:0] pr_last_stamp;
    logic [15:0] pr_frame_count;

    // ------------------------------------------------------------------------
    // Mismatch reporting; printing is capped, counting is not
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP)
        begin
            $display("[%0t] stream error: %s", $time, what);
        end
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Frame prediction
    // ------------------------------------------------------------------------
    function automatic void emit_raw(input logic [7:0] b);
        run_bytes.push_back(b);
    endfunction

    // data bytes equal to ESC are followed by a stuffing byte
    function automatic void emit_data(input logic [7:0] b);
        emit_raw(b);
        if (b == ESC_CHAR)
        begin
            emit_raw(STUFF_CHAR);
        end
    endfunction

    function automatic void emit_mark(input logic [7:0] m);
        emit_raw(ESC_CHAR);
        emit_raw(m);
    endfunction

    function automatic void predict_frame_bytes(input capture_item_t it);
        logic [15:0] elapsed;
        stream_byte_t sb;
        run_bytes.delete();
        if (it.func == FUNC_START)
        begin
            // a start always emits a full header, even over an open frame
            elapsed = it.timestamp - pr_last_stamp;
            emit_mark(MARK_HEADER);
            emit_data(elapsed[7:0]);
            emit_data(elapsed[15:8]);
            emit_data(8'h00);
            emit_data(8'h00);
            emit_data(pr_frame_count[7:0]);
            emit_data(pr_frame_count[15:8]);
            emit_mark(MARK_MOSI);
            pr_last_stamp  = it.timestamp;
            pr_frame_count = pr_frame_count + 16'd1;
            pr_frame_open  = 1'b1;
            pr_miso_begun  = 1'b0;
        end
        else if (!pr_frame_open)
        begin
            // nothing open: the item is dropped
        end
        else if (it.func == FUNC_MOSI)
        begin
            if (!pr_miso_begun)
            begin
                emit_data(it.data_byte);
            end
        end
        else if (it.func == FUNC_MISO)
        begin
            if (!pr_miso_begun)
            begin
                emit_mark(MARK_MISO);
                pr_miso_begun = 1'b1;
            end
            emit_data(it.data_byte);
        end
        else
        begin
            if (!pr_miso_begun)
            begin
                emit_mark(MARK_MISO);
            end
            emit_mark(MARK_END);
            pr_frame_open = 1'b0;
            pr_miso_begun = 1'b0;
        end
        foreach (run_bytes[i])
        begin
            sb.value   = run_bytes[i];
            sb.is_last = (i == run_bytes.size() - 1);
            expected_stream.push_back(sb);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_item(input logic [1:0] fn, input logic [7:0] db,
                                       input logic [15:0] ts);
        capture_item_t it;
        it.func      = fn;
        it.data_byte = db;
        it.timestamp = ts;
        pending_items.push_back(it);
        items_queued++;
        if (fn == FUNC_START)
        begin
            last_ts_queued = ts;
        end
    endfunction

    // escape bytes are made common so stuffing gets plenty of exercise
    function automatic logic [7:0] rand_byte();
        logic [7:0] b;
        if ($urandom_range(0, 7) == 0)
        begin
            b = ESC_CHAR;
        end
        else
        begin
            b = 8'($urandom_range(0, 255));
        end
        return b;
    endfunction

    // zero, wrapping and escape-valued elapsed times turn up often
    function automatic logic [15:0] rand_stamp();
        logic [15:0] ts;
        case ($urandom_range(0, 7))
            0:       ts = last_ts_queued;
            1:       ts = last_ts_queued + 16'h1b1b;
            2:       ts = last_ts_queued - 16'd1;
            default: ts = 16'($urandom_range(0, 65535));
        endcase
        return ts;
    endfunction

    // corners: dropped items, stuffing in every section, empty slave-out
    // section, master-out after slave-out, abandoned frame, elapsed wrap
    task automatic queue_directed();
        queue_item(FUNC_MOSI,  8'hff, 16'h0000);  // no frame open
        queue_item(FUNC_MISO,  8'h00, 16'hffff);  // no frame open
        queue_item(FUNC_END,   8'h1b, 16'h0000);  // no frame open
        queue_item(FUNC_START, 8'h00, 16'h1b1b);  // first frame, elapsed from zero
        queue_item(FUNC_MOSI,  8'h00, 16'h0000);
        queue_item(FUNC_MOSI,  8'hff, 16'hffff);
        queue_item(FUNC_MOSI,  8'h1b, 16'h0000);
        queue_item(FUNC_END,   8'hff, 16'h0000);  // slave-out mark inserted by end
        queue_item(FUNC_START, 8'hff, 16'h1b1b);  // zero elapsed
        queue_item(FUNC_MISO,  8'h1b, 16'h0000);
        queue_item(FUNC_MISO,  8'hff, 16'h0000);
        queue_item(FUNC_MOSI,  8'h55, 16'h0000);  // too late, dropped
        queue_item(FUNC_MISO,  8'h00, 16'h0000);
        queue_item(FUNC_END,   8'h00, 16'h0000);
        queue_item(FUNC_END,   8'h00, 16'h0000);  // already closed
        queue_item(FUNC_START, 8'h00, 16'h0000);  // elapsed wraps
        queue_item(FUNC_MOSI,  8'ha5, 16'h0000);
        queue_item(FUNC_START, 8'h00, 16'hffff);  // abandons the open frame
        queue_item(FUNC_MISO,  8'h5a, 16'h0000);
        queue_item(FUNC_END,   8'h00, 16'h0000);
    endtask

    // mostly well-formed frames with random content, some noise and breakage
    task automatic queue_random(input int n);
        int base;
        int kind;
        int n_mosi;
        int n_miso;
        base = items_queued;
        while (items_queued - base < n)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                queue_item(2'($urandom_range(0, 3)), rand_byte(),
                           16'($urandom_range(0, 65535)));
            end
            else
            begin
                n_mosi = $urandom_range(0, 4);
                n_miso = $urandom_range(0, 4);
                queue_item(FUNC_START, rand_byte(), rand_stamp());
                repeat (n_mosi) queue_item(FUNC_MOSI, rand_byte(), rand_stamp());
                repeat (n_miso) queue_item(FUNC_MISO, rand_byte(), rand_stamp());
                if (kind == 1)
                begin
                    // out-of-order master-out byte
                    queue_item(FUNC_MOSI, rand_byte(), rand_stamp());
                end
                if (kind != 2)
                begin
                    // kind 2 leaves the frame open for the next start
                    queue_item(FUNC_END, rand_byte(), rand_stamp());
                end
            end
        end
    endtask

    // all items offered and taken, and every predicted byte seen
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_items.size() != 0 || capture_ch.valid
               || expected_stream.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Driver: capture items change on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : capture_driver
        capture_item_t it;
        if (!rst_n)
        begin
            capture_ch.valid <= 1'b0;
        end
        else if (!capture_ch.valid || cap_fire)
        begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
            begin
                it = pending_items.pop_front();
                capture_ch.valid     <= 1'b1;
                capture_ch.func      <= it.func;
                capture_ch.data_byte <= it.data_byte;
                capture_ch.timestamp <= it.timestamp;
            end
            else
            begin
                capture_ch.valid <= 1'b0;
            end
        end
    end

    // receiver ready: random stalls, forced low during the hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            stream_ch.ready <= 1'b0;
        end
        else
        begin
            stream_ch.ready <= !hold_off && ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // long receiver hold-off, counted here so the sender keeps offering items
    // and the command queue fills up behind it
    initial
    begin : receiver_hold_off
        wait (hold_req);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor: both channels sampled on the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : stream_monitor
        capture_item_t it;
        stream_byte_t  want;
        cap_fire <= rst_n && capture_ch.valid && capture_ch.ready;
        if (rst_n)
        begin
            if (capture_ch.valid && capture_ch.ready)
            begin
                it.func      = capture_ch.func;
                it.data_byte = capture_ch.data_byte;
                it.timestamp = capture_ch.timestamp;
                predict_frame_bytes(it);
            end
            if (stream_ch.valid && stream_ch.ready)
            begin
                if (expected_stream.size() == 0)
                begin
                    report_mismatch($sformatf("byte %02h with nothing expected",
                                              stream_ch.out_byte));
                end
                else
                begin
                    want = expected_stream.pop_front();
                    if (stream_ch.out_byte !== want.value)
                    begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  stream_ch.out_byte, want.value));
                    end
                    if (stream_ch.last_of_run !== want.is_last)
                    begin
                        report_mismatch($sformatf("last_of_run %b, expected %b on %02h",
                                                  stream_ch.last_of_run, want.is_last,
                                                  want.value));
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        capture_ch.valid     = 1'b0;
        capture_ch.func      = FUNC_START;
        capture_ch.data_byte = 8'h00;
        capture_ch.timestamp = 16'h0000;
        stream_ch.ready      = 1'b0;
        pr_frame_open  = 1'b0;
        pr_miso_begun  = 1'b0;
        pr_last_stamp  = 16'h0000;
        pr_frame_count = 16'h0000;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed corners, no idling
        queue_directed();
        wait_drained();

        // random frames under each idle mix
        queue_random(RANDOM_ITEMS);
        wait_drained();

        src_idle_pct = 49;
        queue_random(RANDOM_ITEMS);
        wait_drained();

        src_idle_pct   = 0;
        sink_stall_pct = 49;
        queue_random(RANDOM_ITEMS);
        wait_drained();

        src_idle_pct   = 19;
        sink_stall_pct = 19;
        queue_random(RANDOM_ITEMS);
        wait_drained();

        // back-pressure: receiver held off while items keep coming
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_req = 1'b1;
        queue_random(RANDOM_ITEMS);
        wait_drained();

        // let any stray bytes surface
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
